FILE: hdl/lcdbr_pkg.sv
// Shared types, constants and helper functions for the character LCD
// buffer/refresh block. No dependencies; imported by every module.

package lcdbr_pkg;

  localparam int LINE_WIDTH = 20;
  localparam int LINE_COUNT = 4;
  localparam int FB_DEPTH   = LINE_WIDTH * LINE_COUNT;
  localparam int ADDR_W     = $clog2(FB_DEPTH);
  localparam int COL_W      = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
  localparam int LINE_IDX_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

  localparam int INIT_SINGLE = 4;
  localparam int INIT_BYTES  = 10;
  localparam int INIT_LAST   = INIT_BYTES - 1;
  localparam int CNT_MAX     = (LINE_WIDTH > INIT_LAST) ? LINE_WIDTH : INIT_LAST;
  localparam int CNT_W       = $clog2(CNT_MAX + 1);

  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CMD_WAKE       = 8'h3F;
  localparam logic [7:0] CMD_SET_4BIT   = 8'h20;
  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h07;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;

  localparam logic [7:0] LINE0_ADDR_RST = 8'h80;
  localparam logic [7:0] LINE1_ADDR_RST = 8'hC0;
  localparam logic [7:0] LINE2_ADDR_RST = 8'h94;
  localparam logic [7:0] LINE3_ADDR_RST = 8'hD4;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_INIT  = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    CFG_OUTPUT_ENABLE = 3'd0,
    CFG_PANEL_SELECT  = 3'd1,
    CFG_LINE0_ADDRESS = 3'd2,
    CFG_LINE1_ADDRESS = 3'd3,
    CFG_LINE2_ADDRESS = 3'd4,
    CFG_LINE3_ADDRESS = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_INIT
  } seq_state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] line;
    logic [4:0] column;
    logic [7:0] char_code;
  } req_t;

  typedef struct packed {
    logic [2:0] select_bits;
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } nib_t;

  typedef struct packed {
    logic            output_enable;
    logic [2:0]      panel_select;
    logic [3:0][7:0] ddram_cmd;
  } cfg_regs_t;

  typedef struct packed {
    logic                  wr;
    logic                  clr;
    logic [LINE_IDX_W-1:0] line;
    logic [COL_W-1:0]      col;
    logic [7:0]            data;
    logic [LINE_IDX_W-1:0] rd_line;
    logic [COL_W-1:0]      rd_col;
  } fb_cmd_t;

  function automatic logic [ADDR_W-1:0] fb_addr(input logic [LINE_IDX_W-1:0] ln,
                                                input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(ln) * ADDR_W'(LINE_WIDTH);
    return base + ADDR_W'(col);
  endfunction

  function automatic logic [7:0] init_byte(input logic [CNT_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      CNT_W'(0): b = CMD_WAKE;
      CNT_W'(1): b = CMD_WAKE;
      CNT_W'(2): b = CMD_WAKE;
      CNT_W'(3): b = CMD_SET_4BIT;
      CNT_W'(4): b = CMD_FUNC_SET;
      CNT_W'(5): b = CMD_DISP_OFF;
      CNT_W'(6): b = CMD_CLEAR;
      CNT_W'(7): b = CMD_HOME;
      CNT_W'(8): b = CMD_ENTRY_MODE;
      CNT_W'(9): b = CMD_DISP_ON;
      default:   b = CHAR_SPACE;
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/lcdbr_fbuf.sv
// Character frame buffer: one-write/one-read memory with registered read,
// plus per-entry valid bits so unwritten or cleared entries read as space.
// Depends on lcdbr_pkg.

module lcdbr_fbuf (
  input  logic              clk,
  input  logic              rst,
  input  lcdbr_pkg::fb_cmd_t cmd,
  output logic [7:0]        rd_char
);
  import lcdbr_pkg::*;

  logic [7:0] mem [FB_DEPTH];
  logic [LINE_COUNT-1:0][LINE_WIDTH-1:0] vld;
  logic [7:0] rd_q;
  logic       rd_vld;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[fb_addr(cmd.line, cmd.col)] <= cmd.data;
    end
    rd_q   <= mem[fb_addr(cmd.rd_line, cmd.rd_col)];
    rd_vld <= vld[cmd.rd_line][cmd.rd_col];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.clr) begin
      vld[cmd.line] <= '0;
    end else if (cmd.wr) begin
      vld[cmd.line][cmd.col] <= 1'b1;
    end
  end

  assign rd_char = rd_vld ? rd_q : CHAR_SPACE;

endmodule

FILE: hdl/lcdbr_seq.sv
// Request sequencer: decodes requests, walks flush and power-up sequences and
// shifts each byte out one nibble per cycle, unless the receiver stalls, into
// the output register. Depends on lcdbr_pkg.

module lcdbr_seq (
  input  logic                clk,
  input  logic                rst,
  input  lcdbr_pkg::cfg_regs_t cfg,
  input  lcdbr_pkg::req_t      req,
  input  logic                req_valid,
  output logic                req_stall,
  output lcdbr_pkg::nib_t      nib,
  output logic                nib_valid,
  input  logic                nib_stall,
  output lcdbr_pkg::fb_cmd_t   fb_cmd,
  input  logic [7:0]          rd_char
);
  import lcdbr_pkg::*;

  seq_state_t            state, state_next;
  logic [7:0]            cur_byte;
  logic                  half;
  logic                  rs;
  logic [CNT_W-1:0]      cnt;
  logic [LINE_IDX_W-1:0] line_r;

  logic accept, adv, single, last_nib, start_flush, start_init;
  logic in_range_line, in_range_col;

  assign in_range_line = 32'(req.line) < LINE_COUNT;
  assign in_range_col  = 32'(req.column) < LINE_WIDTH;
  assign accept        = req_valid && !req_stall;
  assign start_flush   = accept && req.req_type == REQ_FLUSH && cfg.output_enable
                         && in_range_line;
  assign start_init    = accept && req.req_type == REQ_INIT;
  assign adv           = state != ST_IDLE && (!nib_valid || !nib_stall);
  assign single        = state == ST_INIT && cnt < CNT_W'(INIT_SINGLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_flush) begin
          state_next = ST_FLUSH;
        end else if (start_init) begin
          state_next = ST_INIT;
        end
      end
      ST_FLUSH, ST_INIT: begin
        if (adv && last_nib) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    last_nib       = 1'b0;
    req_stall      = 1'b1;
    fb_cmd.wr      = 1'b0;
    fb_cmd.clr     = 1'b0;
    fb_cmd.line    = req.line[LINE_IDX_W-1:0];
    fb_cmd.col     = req.column[COL_W-1:0];
    fb_cmd.data    = req.char_code;
    fb_cmd.rd_line = line_r;
    fb_cmd.rd_col  = (cnt < CNT_W'(LINE_WIDTH)) ? cnt[COL_W-1:0] : '0;
    unique case (state)
      ST_IDLE: begin
        req_stall  = 1'b0;
        fb_cmd.wr  = req_valid && req.req_type == REQ_WRITE && in_range_line
                     && in_range_col;
        fb_cmd.clr = req_valid && req.req_type == REQ_CLEAR && in_range_line;
      end
      ST_FLUSH: last_nib = half && cnt == CNT_W'(LINE_WIDTH);
      ST_INIT:  last_nib = (half || single) && cnt == CNT_W'(INIT_LAST);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      nib_valid <= 1'b0;
      cnt       <= '0;
      line_r    <= '0;
    end else begin
      state <= state_next;
      if (adv) begin
        nib_valid <= 1'b1;
      end else if (!nib_stall) begin
        nib_valid <= 1'b0;
      end
      if (start_flush) begin
        cnt    <= '0;
        line_r <= req.line[LINE_IDX_W-1:0];
      end else if (start_init) begin
        cnt <= '0;
      end else if (adv && !last_nib && (half || single)) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_flush) begin
      cur_byte <= cfg.ddram_cmd[req.line];
      rs       <= 1'b0;
      half     <= 1'b0;
    end else if (start_init) begin
      cur_byte <= init_byte('0);
      rs       <= 1'b0;
      half     <= 1'b0;
    end else if (adv) begin
      nib.select_bits <= cfg.panel_select;
      nib.reg_select  <= rs;
      nib.nibble      <= cur_byte[7:4];
      nib.last        <= last_nib;
      if (!half && !single) begin
        half     <= 1'b1;
        cur_byte <= {cur_byte[3:0], 4'h0};
      end else begin
        half <= 1'b0;
        if (state == ST_FLUSH) begin
          cur_byte <= rd_char;
          rs       <= 1'b1;
        end else begin
          cur_byte <= init_byte(cnt + 1'b1);
        end
      end
    end
  end

endmodule

FILE: hdl/char_lcd_buffer_refresh_4bit.sv
// Top level of the character LCD buffer/refresh block: configuration
// registers, frame buffer and nibble sequencer.
// Depends on lcdbr_pkg, lcdbr_fbuf and lcdbr_seq.
//
// Usage:
//   req/req_valid/req_stall carries one request (write char, clear line,
//   flush line, power-up init). nib/nib_valid/nib_stall carries one bus nibble
//   per transfer with panel select, RS level and a last flag.
//   cfg_valid/cfg_ready writes registers 0..5; cfg_ready is always high.
// Timing:
//   Write and clear emit nothing. A flush emits 2 + 2*LINE_WIDTH nibbles
//   (42) and power-up init 16, one per cycle while the receiver does not
//   stall, from an 8-bit shift register; the first nibble passes through the
//   state register and then the output register before it is valid. req_stall
//   is high from a flush or init acceptance until its last nibble is loaded,
//   so the next request can enter while that last nibble may still wait.
//   A stalled receiver holds the output register and freezes the sequence.
// Reset:
//   Clears control state; the buffer reads as spaces at once through per-entry
//   valid bits, so no clearing pass is needed.

module char_lcd_buffer_refresh_4bit (
  input  logic            clk,
  input  logic            rst,
  input  lcdbr_pkg::req_t req,
  input  logic            req_valid,
  output logic            req_stall,
  output lcdbr_pkg::nib_t nib,
  output logic            nib_valid,
  input  logic            nib_stall,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [7:0]      cfg_data
);
  import lcdbr_pkg::*;

  cfg_regs_t cfg;
  fb_cmd_t   fb_cmd;
  logic [7:0] rd_char;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_enable <= 1'b0;
      cfg.panel_select  <= '0;
      cfg.ddram_cmd[0]  <= LINE0_ADDR_RST;
      cfg.ddram_cmd[1]  <= LINE1_ADDR_RST;
      cfg.ddram_cmd[2]  <= LINE2_ADDR_RST;
      cfg.ddram_cmd[3]  <= LINE3_ADDR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OUTPUT_ENABLE: cfg.output_enable <= cfg_data[0];
        CFG_PANEL_SELECT:  cfg.panel_select  <= cfg_data[2:0];
        CFG_LINE0_ADDRESS: cfg.ddram_cmd[0]  <= cfg_data;
        CFG_LINE1_ADDRESS: cfg.ddram_cmd[1]  <= cfg_data;
        CFG_LINE2_ADDRESS: cfg.ddram_cmd[2]  <= cfg_data;
        CFG_LINE3_ADDRESS: cfg.ddram_cmd[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  lcdbr_fbuf u_fbuf (
    .clk     (clk),
    .rst     (rst),
    .cmd     (fb_cmd),
    .rd_char (rd_char)
  );

  lcdbr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .nib       (nib),
    .nib_valid (nib_valid),
    .nib_stall (nib_stall),
    .fb_cmd    (fb_cmd),
    .rd_char   (rd_char)
  );

endmodule

FILE: hdl/lcdbr_chk.sv
// Port-level checker for the character LCD buffer/refresh block, bound to
// the top level. Depends on lcdbr_pkg.

module lcdbr_chk (
  input logic            clk,
  input logic            rst,
  input lcdbr_pkg::req_t req,
  input logic            req_valid,
  input logic            req_stall,
  input lcdbr_pkg::nib_t nib,
  input logic            nib_valid,
  input logic            nib_stall
);
  import lcdbr_pkg::*;

  a_nib_hold: assert property (@(posedge clk) disable iff (rst)
    nib_valid && nib_stall |=> nib_valid && $stable(nib))
    else $error("stalled nibble request dropped or changed");

  a_ready_after_rst: assert property (@(posedge clk)
    rst |=> !req_stall)
    else $error("request channel stalled right after reset");

  a_busy_mid_seq: assert property (@(posedge clk) disable iff (rst)
    nib_valid && !nib.last |-> req_stall)
    else $error("new request taken before sequence finished");

  a_silent_store: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && !nib_valid
      && (req.req_type == REQ_WRITE || req.req_type == REQ_CLEAR)
      |=> !nib_valid)
    else $error("write or clear request produced a nibble");

endmodule

bind char_lcd_buffer_refresh_4bit lcdbr_chk u_lcdbr_chk (
  .clk       (clk),
  .rst       (rst),
  .req       (req),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .nib       (nib),
  .nib_valid (nib_valid),
  .nib_stall (nib_stall)
);
